### rtl/d2t_pkg.sv
// Shared types and constants of the density to transmittance pipeline.
// Used by every module of the block and by the stream interface instances.
package d2t_pkg;

  // Field widths.
  localparam int unsigned DensW  = 16;  // signed Q3.12 sample
  localparam int unsigned CapW   = 15;  // unsigned Q3.12 cap
  localparam int unsigned BlackW = 25;  // unsigned Q1.24 black level
  localparam int unsigned SpanW  = 32;  // unsigned Q16.16 inverse span
  localparam int unsigned TransW = 24;  // unsigned Q8.16 result
  localparam int unsigned CfgW   = 32;  // widest register
  localparam int unsigned CfgIdxW = 2;

  // Internal widths.
  localparam int unsigned YW    = 45;   // d * log2(10), Q.40
  localparam int unsigned KW    = 5;    // whole part of the exponent
  localparam int unsigned FracW = 31;   // fraction in Q1.30, signed
  localparam int unsigned PolyW = 32;   // Horner accumulator, signed Q2.30
  localparam int unsigned TW    = 25;   // transmittance before normalizing, Q1.24

  localparam int unsigned NumCoef = 6;

  localparam logic [29:0] Log2TenQ28 = 30'd891723283;

  typedef logic signed [PolyW-1:0] coef_t;
  localparam coef_t PolyCoef [NumCoef] = '{
    32'sd1433748, 32'sd10327077, 32'sd59596329,
    32'sd257941248, 32'sd744261118, 32'sd1073741824
  };

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DENSITY_CAP  = 2'd0,
    CFG_BLACK_LEVEL  = 2'd1,
    CFG_INVERSE_SPAN = 2'd2
  } cfg_idx_e;

  // Beat payloads of the two channels.
  typedef struct packed {
    logic signed [DensW-1:0] density;
  } sample_t;

  typedef struct packed {
    logic [TransW-1:0] transmittance;
  } result_t;

  // What one Horner cell hands to the next one.
  typedef struct packed {
    logic signed [PolyW-1:0] p;
    logic signed [FracW-1:0] f;
    logic [KW-1:0]           k;
  } poly_t;

endpackage

### rtl/d2t_stream_if.sv
// Valid/ready stream channel carrying one payload beat per handshake.
// The payload type comes from d2t_pkg at the point of instantiation.
interface d2t_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/d2t_range_reduce.sv
// Front stages: density clamp, scaling by log2(10) and split of the exponent
// into a whole shift and a fraction. Depends on d2t_pkg.
module d2t_range_reduce (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic signed [15:0]        density_i,
  input  logic [14:0]               cap_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output d2t_pkg::poly_t            data_o
);
  import d2t_pkg::*;

  localparam int unsigned Stages = 3;
  localparam logic signed [FracW-1:0] FracLim = 31'sd536870912;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] en;

  logic [CapW-1:0]         d_q, d_d;
  logic [YW-1:0]           y_q, y_d;
  logic [YW-1:0]           ysum;
  logic signed [40:0]      neg_frac;
  logic signed [40:0]      f_shift;
  logic [KW-1:0]           k_q, k_d;
  logic signed [FracW-1:0] f_q, f_d;

  // A stage moves when it is empty or its successor moves.
  assign en[Stages-1] = !v_q[Stages-1] || ready_i;
  assign en[1]        = !v_q[1] || en[2];
  assign en[0]        = !v_q[0] || en[1];
  assign ready_o      = en[0];

  always_comb begin
    if (density_i[DensW-1]) begin
      d_d = '0;
    end else if (density_i[CapW-1:0] > cap_i) begin
      d_d = cap_i;
    end else begin
      d_d = density_i[CapW-1:0];
    end
    y_d = YW'(d_q) * YW'(Log2TenQ28);
    // k = round(y); the low 40 bits of y + 1/2 less 1/2 is y - k.
    ysum     = y_q + (YW'(1) << 39);
    k_d      = ysum[44:40];
    neg_frac = $signed({2'b01, 39'd0}) - $signed({1'b0, ysum[39:0]});
    f_shift  = neg_frac >>> 10;
    f_d      = f_shift[FracW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) d_q <= d_d;
    if (en[1] && v_q[0])  y_q <= y_d;
    if (en[2] && v_q[1]) begin
      k_q <= k_d;
      f_q <= f_d;
    end
  end

  assign valid_o  = v_q[Stages-1];
  assign data_o.p = PolyCoef[0];
  assign data_o.f = f_q;
  assign data_o.k = k_q;

  // The largest capped density gives an exponent of about 26.6.
  a_k_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (k_q <= 5'd27))
    else $error("exponent shift out of range");

  a_frac_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (f_q <= FracLim && f_q >= -FracLim))
    else $error("fraction outside one half");

endmodule

### rtl/d2t_horner_cell.sv
// One Horner step of the 2^f polynomial: p <= floor(p * f / 2^30) + coef.
// Fraction and exponent ride along to the next cell. Depends on d2t_pkg.
module d2t_horner_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  d2t_pkg::coef_t   coef_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  d2t_pkg::poly_t   data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output d2t_pkg::poly_t   data_o
);
  import d2t_pkg::*;

  logic                             v_q;
  logic                             en;
  logic signed [PolyW+FracW-1:0]    prod;
  logic signed [PolyW+FracW-1:0]    prod_sh;
  poly_t                            data_q, data_d;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  always_comb begin
    prod     = (PolyW+FracW)'(data_i.p) * (PolyW+FracW)'(data_i.f);
    prod_sh  = prod >>> 30;
    data_d   = data_i;
    data_d.p = prod_sh[PolyW-1:0] + coef_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) data_q <= data_d;
  end

  assign valid_o = v_q;
  assign data_o  = data_q;

  // With |f| <= 1/2 and positive coefficients the accumulator stays positive.
  a_poly_positive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !data_q.p[PolyW-1])
    else $error("Horner accumulator went negative");

endmodule

### rtl/d2t_scale.sv
// Back stages: 2^-k shift with rounding, black level subtraction, scaling
// by the inverse span and saturation into the output register. Uses d2t_pkg.
module d2t_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  d2t_pkg::poly_t     data_i,
  input  logic [24:0]        black_i,
  input  logic [31:0]        span_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [23:0]        trans_o
);
  import d2t_pkg::*;

  localparam int unsigned Stages = 4;
  localparam int unsigned ProdW  = TW + SpanW;
  localparam int unsigned SumW   = 34;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] en;

  logic [PolyW-2:0]  p_pos;
  logic [5:0]        sh;
  logic [SumW-1:0]   rnd;
  logic [SumW-1:0]   tsum;
  logic [SumW-1:0]   tshift;
  logic [TW-1:0]     t_q, t_d;
  logic [TW-1:0]     diff_q, diff_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [TransW-1:0] out_q, out_d;

  assign en[3]   = !v_q[3] || ready_i;
  assign en[2]   = !v_q[2] || en[3];
  assign en[1]   = !v_q[1] || en[2];
  assign en[0]   = !v_q[0] || en[1];
  assign ready_o = en[0];

  always_comb begin
    p_pos  = data_i.p[PolyW-1] ? '0 : data_i.p[PolyW-2:0];
    sh     = 6'(data_i.k) + 6'd6;
    rnd    = SumW'(1) << (sh - 6'd1);
    tsum   = SumW'(p_pos) + rnd;
    tshift = tsum >> sh;
    t_d    = tshift[TW-1:0];
    diff_d = (t_q > black_i) ? (t_q - black_i) : '0;
    prod_d = ProdW'(diff_q) * ProdW'(span_i);
    out_d  = (|prod_q[ProdW-1:48]) ? {TransW{1'b1}} : prod_q[47:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) t_q    <= t_d;
    if (en[1] && v_q[0])  diff_q <= diff_d;
    if (en[2] && v_q[1])  prod_q <= prod_d;
    if (en[3] && v_q[2])  out_q  <= out_d;
  end

  assign valid_o = v_q[3];
  assign trans_o = out_q;

endmodule

### rtl/density_to_transmittance.sv
// Top level of the density to transmittance pipeline.
// Depends on d2t_pkg, d2t_stream_if, d2t_range_reduce, d2t_horner_cell
// and d2t_scale.
//
// Usage:
//   sample_i carries one signed Q3.12 optical density per beat; result_o
//   returns one unsigned Q8.16 transmittance per beat, in the same order.
//   Every accepted sample gives exactly one result. The user writes the
//   three registers (density cap, black level, inverse span) through
//   cfg_we_i / cfg_idx_i / cfg_data_i only while no beat is in flight;
//   the block does not enforce it. A write past the list is dropped.
// Pipeline and throughput:
//   A sample passes three front stages (clamp, log2(10) multiply,
//   exponent split), a row of five Horner cells, each owning one
//   coefficient and one multiplier, and four back stages (rounding
//   shift, black level, span multiply, saturation into the output
//   register). One sample can enter every cycle while nothing stalls.
// Stalls:
//   Each stage moves when it is empty or the stage after it moves, so a
//   receiver that holds ready low fills the bubbles in the pipeline first;
//   sample_i.ready only drops once every stage holds a beat.
// Reset:
//   Reset empties the pipeline and restores the registers to a cap of
//   32767, a black level of zero and an inverse span of one.
module density_to_transmittance (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  d2t_stream_if.sink                    sample_i,
  d2t_stream_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [d2t_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [d2t_pkg::CfgW-1:0]      cfg_data_i
);
  import d2t_pkg::*;

  localparam int unsigned NumCells = NumCoef - 1;

  // Configuration registers.
  logic [CapW-1:0]   cap_q;
  logic [BlackW-1:0] black_q;
  logic [SpanW-1:0]  span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= {CapW{1'b1}};
      black_q <= '0;
      span_q  <= SpanW'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DENSITY_CAP:  cap_q   <= cfg_data_i[CapW-1:0];
        CFG_BLACK_LEVEL:  black_q <= cfg_data_i[BlackW-1:0];
        CFG_INVERSE_SPAN: span_q  <= cfg_data_i[SpanW-1:0];
        default: ;
      endcase
    end
  end

  // Links of the cell row: index 0 comes from the front stages, the last
  // one feeds the back stages.
  logic  [NumCells:0] link_valid;
  logic  [NumCells:0] link_ready;
  poly_t              link_data [NumCells+1];

  d2t_range_reduce u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (sample_i.valid),
    .ready_o   (sample_i.ready),
    .density_i (sample_i.payload.density),
    .cap_i     (cap_q),
    .valid_o   (link_valid[0]),
    .ready_i   (link_ready[0]),
    .data_o    (link_data[0])
  );

  // Cell i applies coefficient i+1; the leading coefficient seeds p.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    d2t_horner_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .coef_i  (PolyCoef[i+1]),
      .valid_i (link_valid[i]),
      .ready_o (link_ready[i]),
      .data_i  (link_data[i]),
      .valid_o (link_valid[i+1]),
      .ready_i (link_ready[i+1]),
      .data_o  (link_data[i+1])
    );
  end

  d2t_scale u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (link_valid[NumCells]),
    .ready_o (link_ready[NumCells]),
    .data_i  (link_data[NumCells]),
    .black_i (black_q),
    .span_i  (span_q),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .trans_o (result_o.payload.transmittance)
  );

  // With the output register empty, every stage can move, so a sample is
  // always taken.
  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.valid |-> sample_i.ready)
    else $error("input stalled with an empty output register");

  // Input back-pressure only comes from a full pipeline behind a stalled
  // receiver.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (result_o.valid && !result_o.ready))
    else $error("input stalled without a stalled receiver");

endmodule

### dv/d2t_transmittance_check.sv
`timescale 1ns / 1ps
// Watches the sample, result and register channels of density_to_transmittance,
// predicts each transmittance and compares it in order. Depends on d2t_pkg.
module d2t_transmittance_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_valid_i,
  input  logic                         sample_ready_i,
  input  d2t_pkg::sample_t             sample_i,
  input  logic                         result_valid_i,
  input  logic                         result_ready_i,
  input  d2t_pkg::result_t             result_i,
  input  logic                         cfg_we_i,
  input  logic [d2t_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [d2t_pkg::CfgW-1:0]     cfg_data_i,
  output int unsigned                  mismatch_o,
  output int unsigned                  pending_o,
  output int unsigned                  compared_o
);
  import d2t_pkg::*;

  localparam int unsigned MaxReports = 10;
  localparam logic [TransW-1:0] TransMax = '1;

  // 10^-d = 2^-(d * log2 10); log2 10 in Q2.28, Horner coefficients of 2^f in Q2.30.
  localparam longint Log2TenFix = 64'sd891723283;
  localparam longint HalfQ40    = 64'sd1 <<< 39;
  localparam longint Pow2Coef [6] = '{
    64'sd1433748, 64'sd10327077, 64'sd59596329,
    64'sd257941248, 64'sd744261118, 64'sd1073741824
  };

  typedef struct packed {
    logic signed [DensW-1:0] density;
    logic [TransW-1:0]       transmittance;
  } expected_beat_t;

  logic [CapW-1:0]   cap_q;
  logic [BlackW-1:0] black_q;
  logic [SpanW-1:0]  span_q;
  expected_beat_t    expected_trans_q [$];

  function automatic logic [TransW-1:0] predict_transmittance(
    input logic signed [DensW-1:0] density,
    input logic [CapW-1:0]         cap,
    input logic [BlackW-1:0]       black,
    input logic [SpanW-1:0]        span
  );
    longint          d;
    longint          y;
    longint          k;
    longint          g;
    longint          frac;
    longint          acc;
    longint unsigned t;
    longint unsigned scaled;
    int unsigned     shift;
    int              i;
    d = longint'(density);
    if (d < 0) d = 0;
    if (d > longint'(cap)) d = longint'(cap);
    // y in Q.40, split into the nearest whole exponent k and a fraction k - y.
    y = d * Log2TenFix;
    k = (y + HalfQ40) >>> 40;
    g = y - (k <<< 40);
    frac = (-g) >>> 10;
    acc = Pow2Coef[0];
    for (i = 1; i < 6; i++) begin
      acc = ((acc * frac) >>> 30) + Pow2Coef[i];
    end
    if (acc < 0) acc = 0;
    if (k > 40) k = 40;
    shift = 6 + int'(k);
    t = ($unsigned(acc) + (64'd1 << (shift - 1))) >> shift;
    scaled = 0;
    if (t > black) begin
      scaled = ((t - black) * span) >> 24;
      if (scaled > TransMax) scaled = TransMax;
    end
    return scaled[TransW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    expected_beat_t head;
    if (!rst_ni) begin
      cap_q      <= '1;
      black_q    <= '0;
      span_q     <= 32'd65536;
      mismatch_o <= 0;
      pending_o  <= 0;
      compared_o <= 0;
      expected_trans_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DENSITY_CAP:  cap_q   <= cfg_data_i[CapW-1:0];
          CFG_BLACK_LEVEL:  black_q <= cfg_data_i[BlackW-1:0];
          CFG_INVERSE_SPAN: span_q  <= cfg_data_i[SpanW-1:0];
          default: ;
        endcase
      end
      if (result_valid_i && result_ready_i) begin
        if (expected_trans_q.size() == 0) begin
          if (mismatch_o < MaxReports) begin
            $display("%0t: result beat %0d with nothing outstanding",
                     $time, result_i.transmittance);
          end
          mismatch_o <= mismatch_o + 1;
        end else begin
          head = expected_trans_q.pop_front();
          compared_o <= compared_o + 1;
          if (result_i.transmittance !== head.transmittance) begin
            if (mismatch_o < MaxReports) begin
              $display("%0t: density %0d: transmittance expected %0d, got %0d",
                       $time, head.density, head.transmittance, result_i.transmittance);
            end
            mismatch_o <= mismatch_o + 1;
          end
        end
      end
      if (sample_valid_i && sample_ready_i) begin
        expected_trans_q.push_back('{
          density:       sample_i.density,
          transmittance: predict_transmittance(sample_i.density, cap_q, black_q, span_q)
        });
      end
      pending_o <= expected_trans_q.size();
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Top of the density_to_transmittance testbench: clock, reset, sample stimulus,
// register settings and result back-pressure. Depends on d2t_pkg, d2t_stream_if
// and d2t_transmittance_check.
module tb;
  import d2t_pkg::*;

  // Sizes of the run. The cycle limit is far above the slowest correct run:
  // about 1500 beats with random sender gaps and receiver stalls, plus a
  // pipeline drain per register setting.
  localparam int unsigned RandomBeatsPerPhase = 250;
  localparam int unsigned NumRandomPhases     = 6;
  localparam int unsigned SettleCycles        = 24;
  localparam int unsigned CycleLimit          = 600000;

  // Index past the register list; writes to it must be dropped by the block.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  // Back-pressure patterns of the result receiver.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_e;

  logic clk = 1'b0;
  logic rst_n;

  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  d2t_stream_if #(.payload_t(sample_t)) sample_ch ();
  d2t_stream_if #(.payload_t(result_t)) result_ch ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned compared_cnt;

  // Stimulus bookkeeping shared by the tasks below.
  logic [CapW-1:0] cur_cap;
  int unsigned     burst_left;
  int unsigned     beats_sent;
  int unsigned     settings_cnt;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt  = 0;

  always #5 clk = ~clk;

  density_to_transmittance uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .sample_i   (sample_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  d2t_transmittance_check trans_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .sample_valid_i (sample_ch.valid),
    .sample_ready_i (sample_ch.ready),
    .sample_i       (sample_ch.payload),
    .result_valid_i (result_ch.valid),
    .result_ready_i (result_ch.ready),
    .result_i       (result_ch.payload),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatch_o     (mismatch_cnt),
    .pending_o      (pending_cnt),
    .compared_o     (compared_cnt)
  );

  // The receiver switches between back-pressure patterns each time a random
  // countdown runs out: always ready, random stalls, a fixed duty cycle, and
  // long stretches where ready sits high or low. That way stalls land on every
  // stage of the pipeline while it is full, filling and draining.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     result_ch.ready <= 1'b1;
      STALL_RANDOM:   result_ch.ready <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: result_ch.ready <= ((stall_left % 9) < 5);
      default: begin
        if ($urandom_range(0, 15) == 0) result_ch.ready <= ~result_ch.ready;
      end
    endcase
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_cnt, pending_cnt);
      $display("density_to_transmittance regression: fail");
      $finish;
    end
  end

  // Writes all three registers, then an index past the list, one per clock.
  // Bits above each register's width carry random data, which the block must
  // ignore. Only called while no beat is in flight.
  task automatic write_regs(input logic [CapW-1:0] cap, input logic [BlackW-1:0] black,
                            input logic [SpanW-1:0] span);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_DENSITY_CAP;
    cfg_data <= (CfgW'($urandom) << CapW) | CfgW'(cap);
    @(posedge clk);
    cfg_idx  <= CFG_BLACK_LEVEL;
    cfg_data <= (CfgW'($urandom) << BlackW) | CfgW'(black);
    @(posedge clk);
    cfg_idx  <= CFG_INVERSE_SPAN;
    cfg_data <= span;
    @(posedge clk);
    cfg_idx  <= CfgIdxUnused;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_cap = cap;
    settings_cnt++;
  endtask

  // Sends one density beat. The sender runs in bursts of random length; at
  // the start of each burst it may drop valid for a random gap. Within a
  // burst valid stays high; while ready is high, beats go in one per clock.
  // Ready is sampled at the falling edge, where the handshake has settled.
  task automatic stream_density(input logic signed [DensW-1:0] dens);
    int unsigned gap;
    logic        fire;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= '{density: dens};
    fire = 1'b0;
    while (!fire) begin
      @(negedge clk);
      fire = sample_ch.ready;
      @(posedge clk);
    end
    beats_sent++;
  endtask

  // Stops the sender and waits until every expected result has arrived,
  // leaving the block idle for a register update.
  task automatic wait_for_results();
    sample_ch.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending_cnt != 0);
    @(posedge clk);
  endtask

  // Mostly densities inside 0..cap, with negative samples, samples above the
  // cap and fully random words mixed in.
  function automatic logic signed [DensW-1:0] pick_density(input logic [CapW-1:0] cap);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return DensW'($urandom_range(0, cap));
    else if (roll < 80) return DensW'($urandom_range(32768, 65535));
    else if (roll < 88) return DensW'($urandom_range(cap, 32767));
    else return DensW'($urandom);
  endfunction

  initial begin
    logic signed [DensW-1:0] corner_density [12];
    int unsigned phase;
    int unsigned n;

    // Zero, one step each side of zero, the most negative and most positive
    // samples, the two densities around the first exponent rounding point
    // (y = 1/2), and a few whole and fractional densities.
    corner_density = '{
      16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFE,
      16'd616, 16'd617, 16'd2048, 16'd4096, 16'd12288, 16'd20000
    };

    rst_n             = 1'b0;
    sample_ch.valid   = 1'b0;
    sample_ch.payload = '0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_DENSITY_CAP;
    cfg_data          = '0;
    cur_cap           = '1;
    burst_left        = 0;
    beats_sent        = 0;
    settings_cnt      = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first with the reset values of the registers.
    foreach (corner_density[i]) stream_density(corner_density[i]);
    wait_for_results();

    // Cap at density 1.0, black level near 0.1 and the matching stretch:
    // samples at, below and above the cap, and one whose transmittance sits
    // right at the black level.
    write_regs(15'd4096, 25'd1677722, 32'd72818);
    stream_density(16'd4095);
    stream_density(16'd4096);
    stream_density(16'd4097);
    stream_density(16'd0);
    stream_density(16'd4000);
    wait_for_results();

    // Cap of zero with the largest inverse span: every sample saturates.
    write_regs(15'd0, 25'd0, 32'hFFFF_FFFF);
    stream_density(16'd100);
    stream_density(16'hFFFB);
    wait_for_results();

    // Black level of exactly 1.0 and then the largest black level above it:
    // nothing is brighter than black.
    write_regs(15'h7FFF, 25'd16777216, 32'd65536);
    stream_density(16'd0);
    wait_for_results();
    write_regs(15'h7FFF, 25'h1FF_FFFF, 32'hFFFF_FFFF);
    stream_density(16'd0);
    wait_for_results();

    // Zero inverse span maps everything to black.
    write_regs(15'h7FFF, 25'd0, 32'd0);
    stream_density(16'd0);
    stream_density(16'd300);
    wait_for_results();

    // Random part, one register setting per phase, extremes included.
    for (phase = 0; phase < NumRandomPhases; phase++) begin
      case (phase)
        0: write_regs(15'h7FFF, 25'd0, 32'd65536);
        1: write_regs(CapW'($urandom), BlackW'($urandom_range(0, 1 << 23)),
                      $urandom_range(60000, 1 << 20));
        2: write_regs(15'h7FFF, BlackW'($urandom), $urandom);
        3: write_regs(CapW'($urandom), 25'd0, 32'hFFFF_FFFF);
        4: write_regs(CapW'($urandom), BlackW'($urandom_range(0, 1 << 16)), 32'd0);
        default: write_regs(CapW'($urandom), BlackW'($urandom), $urandom);
      endcase
      for (n = 0; n < RandomBeatsPerPhase; n++) stream_density(pick_density(cur_cap));
      wait_for_results();
    end

    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d density beats under %0d register settings; %0d results compared.",
             beats_sent, settings_cnt, compared_cnt);
    $display("Covered clamping on both sides, black level cut-off, zero span and saturation.");
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("density_to_transmittance regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatch_cnt, pending_cnt);
      $display("density_to_transmittance regression: fail");
    end
    $finish;
  end

endmodule
